>>> rtl/core/dtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtm_pkg;

	// parameter defaults
	localparam int SAMPLE_RATE_DEF  = 22050;
	localparam int NUM_CHANNELS_DEF = 3;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// waveform codes
	localparam logic [1:0] SHAPE_SQUARE = 2'd0;
	localparam logic [1:0] SHAPE_TRI    = 2'd1;
	localparam logic [1:0] SHAPE_SAW    = 2'd2;
	localparam logic [1:0] SHAPE_NOISE  = 2'd3;

	// field and state widths
	localparam int MASK_W = 3;
	localparam int REM_W  = 21;

	// noise seed hash
	localparam logic [31:0] SEED_MUL = 32'd2654435761;
	localparam logic [31:0] SEED_XOR = 32'h1234_5678;

	// setup arithmetic: exact reciprocal multiplies
	localparam int             INC_SHIFT  = 33;
	localparam int             DUR_SHIFT  = 26;
	localparam longint         MS_PER_S   = 1000;
	localparam logic [REM_W-1:0] REMAIN_MAX = {REM_W{1'b1}};

	// waveform levels
	localparam int               LEVEL_MAX = 127;
	localparam logic signed [18:0] TRI_BASE = 19'sd65536;
	localparam logic signed [18:0] TRI_PEAK = 19'sd196608;

	// volume scaling: x / 100 as (x * 20972) >> 21, exact for x below 2^14
	localparam logic [14:0] VOL_RECIP = 15'd20972;
	localparam int          VOL_SHIFT = 21;

	// mixer
	localparam int         CLAMP_LIMIT = 255;
	localparam logic [7:0] SILENCE     = 8'd128;

	// per-channel oscillator state
	typedef struct packed {
		logic             active;
		logic [31:0]      phase;
		logic [31:0]      incr;
		logic [6:0]       gain;
		logic [1:0]       shape;
		logic [31:0]      lfsr;
		logic [REM_W-1:0] remaining;
	} chan_t;

	// partial results of a start transaction, one register stage deep
	typedef struct packed {
		logic [31:0] incr_whole;
		logic [15:0] incr_frac;
		logic [31:0] seed;
		logic [22:0] rem_whole;
		logic [15:0] rem_frac;
	} setup_t;

endpackage

`default_nettype wire

>>> rtl/core/three_channel_dds_tone_mixer.sv
// Multi-channel tone generator with a 32-bit phase accumulator per channel.
// One transaction is accepted every clock cycle while the output side keeps
// up; start and stop transactions update channel state and give no result,
// a tick gives one mixed sample. A tick's sample passes the input register,
// the channel state stage, the gain multiply, the volume scaling multiply
// and the mixer output register. These registers split up the reciprocal
// multiplies that turn frequency and duration into increment and sample
// count, the gain multiply and the volume scaling multiply.
// Channel state is read and written in the second stage only, so transactions
// take effect strictly in order. Writing sound_enable to 0 makes every tick
// return 128 without advancing any channel.
`timescale 1ns / 1ps
`default_nettype none

module three_channel_dds_tone_mixer #(
	parameter int SAMPLE_RATE  = dtm_pkg::SAMPLE_RATE_DEF,
	parameter int NUM_CHANNELS = dtm_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_wr_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [1:0]                  operation,
	input  logic [1:0]                  channel_index,
	input  logic [15:0]                 tone_frequency,
	input  logic [6:0]                  channel_volume,
	input  logic [1:0]                  wave_shape,
	input  logic [15:0]                 tone_duration,
	output logic                        sample_valid,
	input  logic                        sample_stall,
	output logic [7:0]                  audio_sample,
	output logic [dtm_pkg::MASK_W-1:0]  active_mask
);
	import dtm_pkg::*;

	localparam int SUM_W = 10 + $clog2(NUM_CHANNELS);

	logic enable_q;

	// stage 1: input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [1:0]  ch_s1;
	logic [15:0] freq_s1;
	logic [6:0]  vol_s1;
	logic [1:0]  shape_s1;
	logic [15:0] dur_s1;
	setup_t      setup_w;

	// stage 2: channel state access
	logic        valid_s2;
	logic [1:0]  op_s2;
	logic [1:0]  ch_s2;
	logic        fzero_s2;
	logic [6:0]  vol_s2;
	logic [1:0]  shape_s2;
	setup_t      setup_s2;
	chan_t       start_chan;
	logic [23:0] rem_sum;

	chan_t             chan_q   [NUM_CHANNELS];
	chan_t             chan_nxt [NUM_CHANNELS];
	logic signed [7:0] level_w  [NUM_CHANNELS];
	logic signed [14:0] prod_d  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] mask_d;

	// stage 3: gain products
	logic                    valid_s3;
	logic                    mute_s3;
	logic [NUM_CHANNELS-1:0] mask_s3;
	logic signed [14:0]      prod_s3 [NUM_CHANNELS];

	// stage 4: scaled voices
	logic                    valid_s4;
	logic                    mute_s4;
	logic [NUM_CHANNELS-1:0] mask_s4;
	logic [7:0]              q_s4   [NUM_CHANNELS];
	logic                    neg_s4 [NUM_CHANNELS];
	logic [7:0]              q_d    [NUM_CHANNELS];

	// output register
	logic              out_valid_q;
	logic [7:0]        audio_sample_q;
	logic [MASK_W-1:0] active_mask_q;
	logic [MASK_W-1:0] mask_out;
	logic [7:0]        sample_d;

	// flow control
	logic go_out, go_s4, go_s3, go_s2, go_s1;
	logic is_tick_s2, leave_s2, commit_s2;

	assign go_out     = !out_valid_q || !sample_stall;
	assign go_s4      = !valid_s4 || go_out;
	assign go_s3      = !valid_s3 || go_s4;
	assign is_tick_s2 = (op_s2 == OP_TICK);
	assign leave_s2   = is_tick_s2 ? go_s3 : 1'b1;
	assign go_s2      = !valid_s2 || leave_s2;
	assign go_s1      = !valid_s1 || go_s2;
	assign commit_s2  = valid_s2 && leave_s2;
	assign item_stall = !go_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && item_valid) begin
			op_s1    <= operation;
			ch_s1    <= channel_index;
			freq_s1  <= tone_frequency;
			vol_s1   <= channel_volume;
			shape_s1 <= wave_shape;
			dur_s1   <= tone_duration;
		end
	end

	// start arithmetic
	dtm_setup #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_setup (
		.freq  (freq_s1),
		.dur   (dur_s1),
		.setup (setup_w)
	);

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2 && valid_s1) begin
			op_s2    <= op_s1;
			ch_s2    <= ch_s1;
			fzero_s2 <= (freq_s1 == '0);
			vol_s2   <= vol_s1;
			shape_s2 <= shape_s1;
			setup_s2 <= setup_w;
		end
	end

	// new channel state for a start transaction
	assign rem_sum = {1'b0, setup_s2.rem_whole} + 24'(setup_s2.rem_frac);

	always_comb begin
		start_chan.active    = 1'b1;
		start_chan.phase     = '0;
		start_chan.incr      = setup_s2.incr_whole + 32'(setup_s2.incr_frac);
		start_chan.gain      = vol_s2;
		start_chan.shape     = shape_s2;
		start_chan.lfsr      = setup_s2.seed;
		start_chan.remaining = (rem_sum > 24'(REMAIN_MAX)) ? REMAIN_MAX : rem_sum[REM_W-1:0];
	end

	// per-channel oscillators and gain products
	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		logic signed [14:0] lvl_x;
		logic signed [14:0] gain_x;

		dtm_voice u_voice (
			.cur   (chan_q[c]),
			.nxt   (chan_nxt[c]),
			.level (level_w[c])
		);

		assign lvl_x     = 15'(level_w[c]);
		assign gain_x    = $signed(15'(chan_q[c].gain));
		assign prod_d[c] = lvl_x * gain_x;
		assign mask_d[c] = enable_q ? chan_nxt[c].active : chan_q[c].active;
	end

	// channel state update, once per transaction leaving stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				chan_q[c] <= '0;
			end
		end else if (commit_s2) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				case (op_s2)
					OP_TICK: begin
						if (enable_q) begin
							chan_q[c] <= chan_nxt[c];
						end
					end
					OP_START: begin
						if (32'(ch_s2) == c) begin
							if (fzero_s2) begin
								chan_q[c].active <= 1'b0;
								chan_q[c].incr   <= '0;
							end else begin
								chan_q[c] <= start_chan;
							end
						end
					end
					OP_STOP: begin
						if (32'(ch_s2) == c) begin
							chan_q[c].active <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// stage 3: register gain products of ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (go_s3) begin
			valid_s3 <= valid_s2 && is_tick_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s3 && valid_s2 && is_tick_s2) begin
			mute_s3 <= !enable_q;
			mask_s3 <= mask_d;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				prod_s3[c] <= prod_d[c];
			end
		end
	end

	// volume divide by reciprocal multiply on the magnitude
	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_scale
		logic [13:0] mag;
		logic [28:0] recip_p;

		assign mag     = prod_s3[c][14] ? 14'(-prod_s3[c]) : 14'(prod_s3[c]);
		assign recip_p = 29'(mag) * 29'(VOL_RECIP);
		assign q_d[c]  = recip_p[VOL_SHIFT +: 8];
	end

	// stage 4 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (go_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s4 && valid_s3) begin
			mute_s4 <= mute_s3;
			mask_s4 <= mask_s3;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				q_s4[c]   <= q_d[c];
				neg_s4[c] <= prod_s3[c][14];
			end
		end
	end

	// mix, clamp, halve and offset to unsigned
	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] vq;
		logic signed [9:0]       clip;
		logic signed [9:0]       half;
		sum = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			vq  = $signed(SUM_W'(q_s4[c]));
			sum = neg_s4[c] ? (sum - vq) : (sum + vq);
		end
		if (sum > SUM_W'(CLAMP_LIMIT)) begin
			clip = 10'(CLAMP_LIMIT);
		end else if (sum < -SUM_W'(CLAMP_LIMIT)) begin
			clip = -10'(CLAMP_LIMIT);
		end else begin
			clip = 10'(sum);
		end
		half     = (clip + $signed({9'd0, clip[9]})) >>> 1;
		sample_d = mute_s4 ? SILENCE : (8'(half) + SILENCE);
	end

	// active mask bits for the addressable channels
	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < NUM_CHANNELS) begin : g_on
			assign mask_out[i] = mask_s4[i];
		end else begin : g_off
			assign mask_out[i] = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_out) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out && valid_s4) begin
			audio_sample_q <= sample_d;
			active_mask_q  <= mask_out;
		end
	end

	assign sample_valid = out_valid_q;
	assign audio_sample = audio_sample_q;
	assign active_mask  = active_mask_q;

	// a muted tick always yields silence
	a_mute_silence: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && go_out && mute_s4) |=> (audio_sample == SILENCE))
		else $error("muted tick did not give silence");

	// the half-scale mix never reaches the bottom code
	a_mix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && go_out && !mute_s4) |=> (audio_sample != 8'd0))
		else $error("mixed sample out of range");

	// a blocked stage 4 sample is kept, not lost
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !go_out) |=> valid_s4)
		else $error("stage 4 sample dropped while output blocked");

	// a committed stop leaves channel 0 silent
	a_stop_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_s2 && (op_s2 == OP_STOP) && (ch_s2 == 2'd0)) |=> !chan_q[0].active)
		else $error("stop transaction did not deactivate channel");

endmodule

`default_nettype wire

>>> rtl/core/dtm_setup.sv
`timescale 1ns / 1ps
`default_nettype none

module dtm_setup #(
	parameter int SAMPLE_RATE = dtm_pkg::SAMPLE_RATE_DEF
) (
	input  logic [15:0]     freq,
	input  logic [15:0]     dur,
	output dtm_pkg::setup_t setup
);
	import dtm_pkg::*;

	// freq * 2^32 / rate = freq * q0 + freq * r0 / rate
	localparam longint RATE   = longint'(SAMPLE_RATE);
	localparam longint INC_Q0 = (64'sd1 <<< 32) / RATE;
	localparam longint INC_R0 = (64'sd1 <<< 32) % RATE;
	localparam longint INC_MF = ((INC_R0 <<< INC_SHIFT) + RATE - 1) / RATE;
	// dur * rate / 1000 = dur * a + dur * b / 1000
	localparam longint DUR_A  = RATE / MS_PER_S;
	localparam longint DUR_B  = RATE % MS_PER_S;
	localparam longint DUR_M  = ((DUR_B <<< DUR_SHIFT) + MS_PER_S - 1) / MS_PER_S;

	localparam logic [19:0] INC_Q0_C = 20'(INC_Q0);
	localparam logic [32:0] INC_MF_C = 33'(INC_MF);
	localparam logic [6:0]  DUR_A_C  = 7'(DUR_A);
	localparam logic [25:0] DUR_M_C  = 26'(DUR_M);

	logic [35:0] inc_whole_p;
	logic [48:0] inc_frac_p;
	logic [31:0] seed_p;
	logic [31:0] seed_x;
	logic [22:0] rem_whole_p;
	logic [41:0] rem_frac_p;

	// phase increment partial products
	assign inc_whole_p = 36'(freq) * 36'(INC_Q0_C);
	assign inc_frac_p  = 49'(freq) * 49'(INC_MF_C);

	// noise seed, never zero
	assign seed_p = 32'(freq) * SEED_MUL;
	assign seed_x = SEED_XOR ^ seed_p;

	// duration in samples, partial products
	assign rem_whole_p = 23'(dur) * 23'(DUR_A_C);
	assign rem_frac_p  = 42'(dur) * 42'(DUR_M_C);

	always_comb begin
		setup.incr_whole = inc_whole_p[31:0];
		setup.incr_frac  = inc_frac_p[INC_SHIFT +: 16];
		setup.seed       = (seed_x == '0) ? 32'd1 : seed_x;
		setup.rem_whole  = rem_whole_p;
		setup.rem_frac   = rem_frac_p[DUR_SHIFT +: 16];
	end

endmodule

`default_nettype wire

>>> rtl/core/dtm_voice.sv
`timescale 1ns / 1ps
`default_nettype none

module dtm_voice (
	input  dtm_pkg::chan_t     cur,
	output dtm_pkg::chan_t     nxt,
	output logic signed [7:0]  level
);
	import dtm_pkg::*;

	logic [17:0]        p4;
	logic signed [18:0] tri_w;
	logic signed [7:0]  tri_lvl;
	logic               fb;

	// triangle from the upper phase half-word, clipped to the level range
	assign p4    = {cur.phase[31:16], 2'b00};
	assign tri_w = cur.phase[31] ? (TRI_PEAK - $signed({1'b0, p4}))
	                             : ($signed({1'b0, p4}) - TRI_BASE);
	assign tri_lvl = (tri_w > 19'(LEVEL_MAX))  ? 8'(LEVEL_MAX) :
	                 (tri_w < -19'(LEVEL_MAX)) ? -8'(LEVEL_MAX) :
	                 $signed(tri_w[7:0]);

	// lfsr feedback taps
	assign fb = cur.lfsr[0] ^ cur.lfsr[2] ^ cur.lfsr[3] ^ cur.lfsr[5];

	// one sample step of an active channel
	always_comb begin
		nxt   = cur;
		level = '0;
		if (cur.active) begin
			case (cur.shape)
				SHAPE_SQUARE: begin
					level = cur.phase[31] ? 8'(LEVEL_MAX) : -8'(LEVEL_MAX);
				end
				SHAPE_TRI: begin
					level = tri_lvl;
				end
				SHAPE_SAW: begin
					level = $signed({~cur.phase[31], cur.phase[30:24]});
				end
				SHAPE_NOISE: begin
					nxt.lfsr = {fb, cur.lfsr[31:1]};
					level    = $signed({~fb, cur.lfsr[31:25]});
				end
				default: begin
					level = '0;
				end
			endcase
			nxt.phase = cur.phase + cur.incr;
			// countdown, channel ends when it runs out
			if (cur.remaining != '0) begin
				nxt.remaining = cur.remaining - 1'b1;
				if (cur.remaining == REM_W'(1)) begin
					nxt.active = 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_three_channel_dds_tone_mixer.sv
`timescale 1ns / 1ps

module tb_three_channel_dds_tone_mixer;
	import dtm_pkg::*;

	localparam int RATE = SAMPLE_RATE_DEF;
	localparam int NCH  = NUM_CHANNELS_DEF;

	// operation and channel codes the block must ignore
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [1:0] CH_NONE  = 2'd3;

	localparam int SETTLE_CYCLES = 20;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PRINT_LIMIT   = 200;

	typedef struct packed {
		logic [7:0]        level;
		logic [MASK_W-1:0] mask;
	} mix_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic              cfg_wr_data;
	logic              item_valid;
	logic              item_stall;
	logic [1:0]        operation;
	logic [1:0]        channel_index;
	logic [15:0]       tone_frequency;
	logic [6:0]        channel_volume;
	logic [1:0]        wave_shape;
	logic [15:0]       tone_duration;
	logic              sample_valid;
	logic              sample_stall;
	logic [7:0]        audio_sample;
	logic [MASK_W-1:0] active_mask;

	// predicted oscillator state
	bit          snd_en;
	bit          ch_on    [NCH];
	bit [31:0]   ch_phase [NCH];
	bit [31:0]   ch_inc   [NCH];
	bit [6:0]    ch_gain  [NCH];
	bit [1:0]    ch_wave  [NCH];
	bit [31:0]   ch_noise [NCH];
	bit [20:0]   ch_left  [NCH];

	mix_t pending_mix[$];
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	bit   src_gaps_on = 1'b1;
	bit   snk_stall_on = 1'b1;

	three_channel_dds_tone_mixer #(
		.SAMPLE_RATE  (RATE),
		.NUM_CHANNELS (NCH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.operation      (operation),
		.channel_index  (channel_index),
		.tone_frequency (tone_frequency),
		.channel_volume (channel_volume),
		.wave_shape     (wave_shape),
		.tone_duration  (tone_duration),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.audio_sample   (audio_sample),
		.active_mask    (active_mask)
	);

	// 125 MHz clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// triangle level from the top 16 phase bits, clipped to the sample range
	function automatic int tri_level(input bit [31:0] ph);
		int p;
		int v;
		p = ph[31:16];
		if (p < 32768)
			v = p * 4 - 65536;
		else
			v = 196608 - p * 4;
		if (v > 127) v = 127;
		if (v < -127) v = -127;
		return v;
	endfunction

	// one sample of one voice, advancing its phase, noise and countdown
	function automatic int voice_level(input int c);
		int s;
		bit [31:0] x;
		bit fb;
		if (!ch_on[c])
			return 0;
		case (ch_wave[c])
			SHAPE_SQUARE: s = ch_phase[c][31] ? 127 : -127;
			SHAPE_TRI:    s = tri_level(ch_phase[c]);
			SHAPE_SAW:    s = int'(ch_phase[c][31:24]) - 128;
			default: begin
				x = ch_noise[c];
				fb = x[0] ^ x[2] ^ x[3] ^ x[5];
				x = {fb, x[31:1]};
				ch_noise[c] = x;
				s = int'(x[31:24]) - 128;
			end
		endcase
		ch_phase[c] += ch_inc[c];
		if (ch_left[c] != 0) begin
			ch_left[c]--;
			if (ch_left[c] == 0) ch_on[c] = 1'b0;
		end
		return (s * int'(ch_gain[c])) / 100;
	endfunction

	// apply one accepted transaction; a tick queues the expected mix
	function automatic void mix_step(input logic [1:0] op, input logic [1:0] ch,
			input logic [15:0] freq, input logic [6:0] vol,
			input logic [1:0] shape, input logic [15:0] dur);
		bit [63:0] wide;
		bit [31:0] seed;
		int sum;
		int level;
		mix_t res;
		case (op)
			OP_START: begin
				if (ch < NCH) begin
					if (freq == 0) begin
						ch_on[ch] = 1'b0;
						ch_inc[ch] = '0;
					end else begin
						wide = 64'(dur) * 64'(RATE) / 64'd1000;
						if (wide > 64'h1F_FFFF) wide = 64'h1F_FFFF;
						ch_left[ch] = wide[20:0];
						wide = (64'(freq) << 32) / 64'(RATE);
						ch_inc[ch] = wide[31:0];
						seed = 32'(freq) * 32'd2654435761;
						seed = seed ^ 32'h1234_5678;
						if (seed == 0) seed = 32'd1;
						ch_noise[ch] = seed;
						ch_phase[ch] = '0;
						ch_gain[ch] = vol;
						ch_wave[ch] = shape;
						ch_on[ch] = 1'b1;
					end
				end
			end
			OP_STOP: begin
				if (ch < NCH) ch_on[ch] = 1'b0;
			end
			OP_TICK: begin
				level = 128;
				if (snd_en) begin
					sum = 0;
					for (int c = 0; c < NCH; c++) sum += voice_level(c);
					if (sum > 255) sum = 255;
					if (sum < -255) sum = -255;
					level = 128 + sum / 2;
					if (level < 0) level = 0;
					if (level > 255) level = 255;
				end
				res.level = level[7:0];
				res.mask = '0;
				for (int c = 0; c < NCH; c++) res.mask[c] = ch_on[c];
				pending_mix.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// drive one transaction and predict it once it is taken
	task automatic send_item(input logic [1:0] op, input logic [1:0] ch,
			input logic [15:0] freq, input logic [6:0] vol,
			input logic [1:0] shape, input logic [15:0] dur);
		if (src_gaps_on && $urandom_range(3) == 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat ($urandom_range(13, 1) - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid = 1'b1;
		operation = op;
		channel_index = ch;
		tone_frequency = freq;
		channel_volume = vol;
		wave_shape = shape;
		tone_duration = dur;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		mix_step(op, ch, freq, vol, shape, dur);
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 2'($urandom), 16'($urandom), 7'($urandom), 2'($urandom),
			16'($urandom));
	endtask

	// random transaction, mostly ticks with starts and stops mixed in
	task automatic send_random_item();
		int r;
		logic [1:0] op;
		logic [1:0] ch;
		logic [15:0] freq;
		logic [6:0] vol;
		logic [15:0] dur;
		r = $urandom_range(99);
		if (r < 68) op = OP_TICK;
		else if (r < 84) op = OP_START;
		else if (r < 95) op = OP_STOP;
		else op = OP_SPARE;
		ch = ($urandom_range(15) == 0) ? CH_NONE : 2'($urandom_range(NCH - 1));
		r = $urandom_range(99);
		if (r < 5) freq = '0;
		else if (r < 65) freq = 16'($urandom_range(4000, 20));
		else freq = 16'($urandom);
		vol = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(100));
		r = $urandom_range(99);
		if (r < 35) dur = '0;
		else if (r < 80) dur = 16'($urandom_range(10, 1));
		else dur = 16'($urandom);
		send_item(op, ch, freq, vol, 2'($urandom), dur);
	endtask

	// hold off until every sample is back and the pipeline has drained
	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		wait (pending_mix.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sound_enable(input bit en);
		wait_idle();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = en;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		snd_en = en;
	endtask

	// every waveform at the field extremes, gains above 100 included
	task automatic test_waveforms();
		send_item(OP_START, 2'd0, 16'd1000, 7'd100, SHAPE_SQUARE, 16'd0);
		send_item(OP_START, 2'd1, 16'hFFFF, 7'd127, SHAPE_TRI, 16'hFFFF);
		send_item(OP_START, 2'd2, 16'd1, 7'd0, SHAPE_SAW, 16'd1);
		repeat (4) send_tick();
		send_item(OP_START, 2'd2, 16'd440, 7'd100, SHAPE_NOISE, 16'd0);
		repeat (3) send_tick();
		send_item(OP_START, 2'd0, 16'hFFFF, 7'd127, SHAPE_NOISE, 16'd3);
		repeat (2) send_tick();
	endtask

	// zero frequency, stop, out-of-range channel and the spare operation
	task automatic test_channel_control();
		send_item(OP_START, 2'd1, 16'd0, 7'd50, SHAPE_SAW, 16'd20);
		send_tick();
		send_item(OP_STOP, 2'd0, 16'd0, 7'd0, SHAPE_SQUARE, 16'd0);
		send_tick();
		send_item(OP_START, CH_NONE, 16'd500, 7'd100, SHAPE_SQUARE, 16'd0);
		send_item(OP_STOP, CH_NONE, 16'd0, 7'd0, SHAPE_SQUARE, 16'd0);
		send_item(OP_SPARE, 2'd2, 16'hFFFF, 7'h7F, SHAPE_NOISE, 16'hFFFF);
		send_tick();
		send_item(OP_STOP, 2'd2, 16'd0, 7'd0, SHAPE_SQUARE, 16'd0);
		send_tick();
	endtask

	// muted ticks hold every channel, starts still land
	task automatic test_mute();
		send_item(OP_START, 2'd0, 16'd300, 7'd90, SHAPE_SAW, 16'd0);
		send_item(OP_START, 2'd1, 16'd700, 7'd80, SHAPE_NOISE, 16'd1);
		send_tick();
		write_sound_enable(1'b0);
		repeat (4) send_tick();
		send_item(OP_START, 2'd2, 16'd1200, 7'd100, SHAPE_TRI, 16'd0);
		repeat (2) send_tick();
		send_item(OP_STOP, 2'd0, 16'd0, 7'd0, SHAPE_SQUARE, 16'd0);
		send_tick();
		write_sound_enable(1'b1);
		repeat (4) send_tick();
	endtask

	// random traffic in blocks, the mute setting changing between them
	task automatic test_random_traffic();
		bit en;
		for (int b = 0; b < 8; b++) begin
			en = (b == 3) ? 1'b0 : ($urandom_range(3) != 0);
			write_sound_enable(en);
			repeat (100) send_random_item();
		end
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_steady_tail();
		write_sound_enable(1'b1);
		src_gaps_on = 1'b0;
		snk_stall_on = 1'b0;
		repeat (200) send_random_item();
	endtask

	// output side stall bursts
	initial begin : sink_pacing
		sample_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (snk_stall_on && $urandom_range(3) == 0) begin
				sample_stall = 1'b1;
				repeat ($urandom_range(13, 1)) @(negedge clk);
				sample_stall = 1'b0;
			end else begin
				repeat ($urandom_range(16)) @(negedge clk);
			end
		end
	end

	// compare each sample transaction with the oldest prediction
	always @(posedge clk) begin : check_samples
		mix_t want;
		if (arst_n && sample_valid && !sample_stall) begin
			if (pending_mix.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d mask %b",
					audio_sample, active_mask));
			end else begin
				want = pending_mix.pop_front();
				if (audio_sample !== want.level)
					report_mismatch($sformatf("audio_sample got %0d expected %0d",
						audio_sample, want.level));
				if (active_mask !== want.mask)
					report_mismatch($sformatf("active_mask got %b expected %b",
						active_mask, want.mask));
			end
		end
	end

	// stop a run that makes no progress
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (sample_valid && !sample_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		item_valid = 1'b0;
		operation = OP_TICK;
		channel_index = '0;
		tone_frequency = '0;
		channel_volume = '0;
		wave_shape = SHAPE_SQUARE;
		tone_duration = '0;
		snd_en = 1'b1;
		for (int c = 0; c < NCH; c++) begin
			ch_on[c] = 1'b0;
			ch_phase[c] = '0;
			ch_inc[c] = '0;
			ch_gain[c] = '0;
			ch_wave[c] = '0;
			ch_noise[c] = '0;
			ch_left[c] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_sound_enable(1'b1);
		test_waveforms();
		test_channel_control();
		test_mute();
		test_random_traffic();
		test_steady_tail();

		// drain and give stray samples a chance to show up
		@(negedge clk);
		item_valid = 1'b0;
		wait (pending_mix.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/dtm_pkg.sv
rtl/core/dtm_setup.sv
rtl/core/dtm_voice.sv
rtl/core/three_channel_dds_tone_mixer.sv
dv/tb_three_channel_dds_tone_mixer.sv
